>>> design/srsw_pkg.sv
// shared constants, codes and types of the selective-repeat sender window
package srsw_pkg;

    localparam int WINDOW_MAX  = 16;
    localparam int MAX_PACKETS = 1024;

    localparam int NUM_W   = 10;
    localparam int TOT_W   = 10;
    localparam int WSZ_W   = 5;
    localparam int TMO_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ST_W    = 2;
    localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
    localparam int ADDR_W  = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;

    typedef enum logic [1:0] {
        KIND_NEW    = 2'd0,
        KIND_RESEND = 2'd1,
        KIND_END    = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    localparam logic [ST_W-1:0] ST_UNSENT = 2'd0;
    localparam logic [ST_W-1:0] ST_WAIT   = 2'd1;
    localparam logic [ST_W-1:0] ST_ACKED  = 2'd2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ACK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    typedef struct packed {
        logic              inc;
        logic              clr;
        logic [SLOT_W-1:0] slot;
    } t_tmr_ctl;

    typedef struct packed {
        t_kind             kind;
        logic [NUM_W-1:0]  pkt;
        logic [NUM_W-1:0]  base;
        logic              fin;
        logic              last;
    } t_result;

endpackage

>>> design/selective_repeat_sender_window_unit.sv
// sender side of a selective-repeat window: sequencer, status store and config
//
// channels: input beats on s_axis carry a tick (tuser 0) or an ack (tuser 1)
// with the packet number in tdata; every input beat yields a run of result
// beats on m_axis (new send, resend, end marker) closed by one status beat
// that has tlast set. the config channel writes total_packets (index 0),
// window_size (index 1) and timeout_ticks (index 2) and is always ready.
// after reset the packet status store is swept, one entry per cycle, over
// all 1024 entries; s_axis_tready stays low until the sweep is done.
// a tick walks the window twice through the shared slot timer unit, one slot
// per cycle unless a result waits for the output register (timer pass, then
// send pass), then checks the end marker.
// an ack writes the status store, then slides the base one packet per cycle;
// an ack at or above the total skips the store and the slide.
// one item is worked at a time; s_axis_tready is high only while the block
// waits for input.
// results leave through an output register; when the receiver stalls, the
// sequencer holds at the next beat until the register frees up.
module selective_repeat_sender_window_unit
    import srsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [9:0] ack_number
    input  logic                 s_axis_tuser,   // [0] cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // [9:0] packet_number, [19:10] window_base, [20] finished
    output logic [1:0]           m_axis_tuser,   // [1:0] kind
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [8:0] {
        S_CLEAR     = 9'b000000001,
        S_IDLE      = 9'b000000010,
        S_SLIDE_RD  = 9'b000000100,
        S_SLIDE_CHK = 9'b000001000,
        S_SCAN_T    = 9'b000010000,
        S_SCAN_N    = 9'b000100000,
        S_END_RD    = 9'b001000000,
        S_END_CHK   = 9'b010000000,
        S_STATUS    = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [NUM_W-1:0]    r_base, n_base;
    logic [SLOT_W-1:0]   r_base_slot, n_base_slot;
    logic [NUM_W-1:0]    r_idx, n_idx;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [NUM_W-1:0]    r_top, n_top;
    logic                r_end_sent, n_end_sent;
    logic                r_done, n_done;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [TOT_W-1:0]    r_total;
    logic [WSZ_W-1:0]    r_wsize;
    logic [TMO_W-1:0]    r_timeout;

    logic [NUM_W-1:0]    w_eff_total;
    logic [NUM_W-1:0]    w_last_pkt;
    logic [WIN_W-1:0]    w_eff_win;
    logic [NUM_W:0]      w_top_sum;
    logic [NUM_W-1:0]    w_top;
    logic [NUM_W-1:0]    w_ack;
    logic                w_in_acc;

    logic                w_we, w_re;
    logic [ADDR_W-1:0]   w_waddr, w_raddr;
    logic [ST_W-1:0]     w_wdata, w_rdata;

    t_tmr_ctl            w_tmr;
    logic                w_expired;
    logic                w_load, w_can_load;
    t_result             w_res;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(WINDOW_MAX - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    // effective configuration
    always_comb begin
        if (r_total == '0) begin
            w_eff_total = NUM_W'(1);
        end else if (32'(r_total) > MAX_PACKETS) begin
            w_eff_total = NUM_W'(MAX_PACKETS);
        end else begin
            w_eff_total = NUM_W'(r_total);
        end
        if (r_wsize == '0) begin
            w_eff_win = WIN_W'(1);
        end else if (32'(r_wsize) > WINDOW_MAX) begin
            w_eff_win = WIN_W'(WINDOW_MAX);
        end else begin
            w_eff_win = WIN_W'(r_wsize);
        end
    end

    assign w_last_pkt = w_eff_total - NUM_W'(1);
    assign w_top_sum  = {1'b0, r_base} + (NUM_W+1)'(w_eff_win) - (NUM_W+1)'(1);
    assign w_top      = (w_top_sum > {1'b0, w_last_pkt}) ? w_last_pkt : w_top_sum[NUM_W-1:0];
    assign w_ack      = s_axis_tdata[NUM_W-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_base_slot = r_base_slot;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_top       = r_top;
        n_end_sent  = r_end_sent;
        n_done      = r_done;
        n_clr_addr  = r_clr_addr;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = ST_UNSENT;
        w_re        = 1'b0;
        w_raddr     = '0;
        w_tmr.inc   = 1'b0;
        w_tmr.clr   = 1'b0;
        w_tmr.slot  = r_slot;
        w_load      = 1'b0;
        w_res.kind  = KIND_STATUS;
        w_res.pkt   = '0;
        w_res.base  = r_base;
        w_res.fin   = r_done;
        w_res.last  = 1'b0;

        case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = ST_UNSENT;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(MAX_PACKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == CMD_ACK) begin
                        if (w_ack < w_eff_total) begin
                            w_we    = 1'b1;
                            w_waddr = ADDR_W'(w_ack);
                            w_wdata = ST_ACKED;
                            n_state = S_SLIDE_RD;
                        end else begin
                            if (w_ack == w_eff_total) begin
                                n_done = 1'b1;
                            end
                            n_state = S_STATUS;
                        end
                    end else begin
                        n_top = w_top;
                        if (r_base <= w_last_pkt) begin
                            w_re    = 1'b1;
                            w_raddr = ADDR_W'(r_base);
                            n_idx   = r_base;
                            n_slot  = r_base_slot;
                            n_state = S_SCAN_T;
                        end else begin
                            n_state = S_END_RD;
                        end
                    end
                end
            end
            S_SLIDE_RD: begin
                if (r_base < w_last_pkt) begin
                    w_re    = 1'b1;
                    w_raddr = ADDR_W'(r_base);
                    n_state = S_SLIDE_CHK;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_SLIDE_CHK: begin
                if (w_rdata == ST_ACKED) begin
                    n_base      = r_base + NUM_W'(1);
                    n_base_slot = next_slot(r_base_slot);
                    if (n_base < w_last_pkt) begin
                        w_re    = 1'b1;
                        w_raddr = ADDR_W'(n_base);
                    end else begin
                        n_state = S_STATUS;
                    end
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_SCAN_T: begin
                if (!((w_rdata == ST_WAIT) && w_expired && !w_can_load)) begin
                    if (w_rdata == ST_WAIT) begin
                        w_tmr.inc = 1'b1;
                        if (w_expired) begin
                            w_load     = 1'b1;
                            w_res.kind = KIND_RESEND;
                            w_res.pkt  = r_idx;
                        end
                    end
                    w_re = 1'b1;
                    if (r_idx == r_top) begin
                        w_raddr = ADDR_W'(r_base);
                        n_idx   = r_base;
                        n_slot  = r_base_slot;
                        n_state = S_SCAN_N;
                    end else begin
                        n_idx   = r_idx + NUM_W'(1);
                        n_slot  = next_slot(r_slot);
                        w_raddr = ADDR_W'(n_idx);
                    end
                end
            end
            S_SCAN_N: begin
                if (!((w_rdata == ST_UNSENT) && !w_can_load)) begin
                    if (w_rdata == ST_UNSENT) begin
                        w_we       = 1'b1;
                        w_waddr    = ADDR_W'(r_idx);
                        w_wdata    = ST_WAIT;
                        w_tmr.clr  = 1'b1;
                        w_load     = 1'b1;
                        w_res.kind = KIND_NEW;
                        w_res.pkt  = r_idx;
                    end
                    if (r_idx == r_top) begin
                        n_state = S_END_RD;
                    end else begin
                        n_idx   = r_idx + NUM_W'(1);
                        n_slot  = next_slot(r_slot);
                        w_re    = 1'b1;
                        w_raddr = ADDR_W'(n_idx);
                    end
                end
            end
            S_END_RD: begin
                w_re    = 1'b1;
                w_raddr = ADDR_W'(w_last_pkt);
                n_state = S_END_CHK;
            end
            S_END_CHK: begin
                if (!r_end_sent && (r_base == w_last_pkt) && (w_rdata == ST_ACKED)) begin
                    if (w_can_load) begin
                        w_load     = 1'b1;
                        w_res.kind = KIND_END;
                        w_res.pkt  = w_eff_total;
                        n_end_sent = 1'b1;
                        n_state    = S_STATUS;
                    end
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (w_can_load) begin
                    w_load     = 1'b1;
                    w_res.kind = KIND_STATUS;
                    w_res.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_base      <= '0;
            r_base_slot <= '0;
            r_idx       <= '0;
            r_slot      <= '0;
            r_top       <= '0;
            r_end_sent  <= 1'b0;
            r_done      <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_base_slot <= n_base_slot;
            r_idx       <= n_idx;
            r_slot      <= n_slot;
            r_top       <= n_top;
            r_end_sent  <= n_end_sent;
            r_done      <= n_done;
            r_clr_addr  <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= TOT_W'(1);
            r_wsize   <= WSZ_W'(16);
            r_timeout <= TMO_W'(1000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOTAL:   r_total   <= i_cfg_data[TOT_W-1:0];
                CFG_WINDOW:  r_wsize   <= i_cfg_data[WSZ_W-1:0];
                CFG_TIMEOUT: r_timeout <= i_cfg_data[TMO_W-1:0];
                default:     r_total   <= r_total;
            endcase
        end
    end

    srsw_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_PACKETS)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    srsw_timer u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_tmr),
        .i_timeout (r_timeout),
        .o_expired (w_expired)
    );

    srsw_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_res         (w_res),
        .o_can_load    (w_can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_base_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_base >= $past(r_base))
        else $error("window base moved backward");

    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end_sent |=> r_end_sent)
        else $error("end marker flag cleared");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("finished flag cleared");

    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_T || r_state == S_SCAN_N) |-> (r_idx >= r_base && r_idx <= r_top))
        else $error("scan index outside window");

    a_tlast_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_STATUS)))
        else $error("tlast not on status beat");
`endif

endmodule

>>> design/srsw_ram.sv
// generic single-write single-read ram with registered read
module srsw_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/srsw_timer.sv
// slot timer bank with the shared increment and timeout compare
module srsw_timer
    import srsw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tmr_ctl         i_ctl,
    input  logic [TMO_W-1:0] i_timeout,
    output logic             o_expired
);

    logic [TMO_W-1:0] r_timer [WINDOW_MAX];
    logic [TMO_W:0]   w_sum;

    assign w_sum     = {1'b0, r_timer[i_ctl.slot]} + (TMO_W+1)'(1);
    assign o_expired = w_sum > {1'b0, i_timeout};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_MAX; k++) begin
                r_timer[k] <= '0;
            end
        end else if (i_ctl.clr) begin
            r_timer[i_ctl.slot] <= '0;
        end else if (i_ctl.inc) begin
            r_timer[i_ctl.slot] <= o_expired ? '0 : w_sum[TMO_W-1:0];
        end
    end

endmodule

>>> design/srsw_out_stage.sv
// output register of the result stream
module srsw_out_stage
    import srsw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_res,
    output logic        o_can_load,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {3'b000, r_res.fin, r_res.base, r_res.pkt};
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tlast  = r_res.last;

endmodule
